// ----- rtl/srlc_pkg.sv -----
package srlc_pkg;

    localparam int unsigned ENTRIES_DEF = 8;
    localparam int unsigned MAXSEC_W    = 11;
    localparam logic [MAXSEC_W-1:0] MAXSEC_RST = 11'd8;

    typedef enum logic [2:0] {
        K_BYPASS  = 3'd0,
        K_HIT     = 3'd1,
        K_FILL    = 3'd2,
        K_WHOLE   = 3'd3,
        K_PART    = 3'd4,
        K_INVAL   = 3'd5,
        K_WDONE   = 3'd6,
        K_WERR    = 3'd7
    } kind_t;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] first_sector;
        logic [31:0] sector_total;
        logic        disk_ok;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  entry_index;
        logic [31:0] fill_sector;
        logic [31:0] sector_offset;
        logic [31:0] sector_len;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
    } rsp_t;

endpackage

// ----- rtl/srlc_if.sv -----
interface srlc_req_if;
    import srlc_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srlc_rsp_if;
    import srlc_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/srlc_ram.sv -----
module srlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/sector_range_cache_lru_controller.sv -----
// Tag and LRU replacement engine for a fully associative cache of sector ranges.
// Requests arrive on req (op, first_sector, sector_total, disk_ok), results
// leave on rsp; each channel moves one transaction when valid and ready are high.
// The cacheable read limit is written through the APB port at address 0; the user
// must write it only while the block idles, and the block itself does not enforce this.
// A read gives one result: bypass, hit or miss fill. A write with disk_ok low
// gives one write error; otherwise one result per affected entry in index order
// and a final write done carrying last.
// Entry ranges live in a synchronous RAM with a registered read, read one entry per cycle
// while the output register is free; valid bits, recency ranks and counters are flip-flops.
// A new request is taken only when the previous one has finished and the output
// register is free, so the entry scan sets the request rate.
// A single output register holds each result; a stalled receiver holds the
// scan in place until the result is taken.
// Reset clears all valid bits, ranks and hit/miss totals and sets the read
// limit to 8; the RAM contents need no clearing.
module sector_range_cache_lru_controller #(
    parameter int unsigned ENTRIES = srlc_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    srlc_req_if.sink    req,
    srlc_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srlc_pkg::*;

    localparam int unsigned IDXW = $clog2(ENTRIES);
    localparam int unsigned CNTW = $clog2(ENTRIES + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DONE} state_t;

    state_t                state_reg, state_next;
    logic [MAXSEC_W-1:0]   maxsec_reg;
    logic                  op_reg, op_next;
    logic [31:0]           start_reg, start_next;
    logic [31:0]           count_reg, count_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic                  valid_reg [ENTRIES];
    logic                  valid_next [ENTRIES];
    logic [IDXW-1:0]       rank_reg [ENTRIES];
    logic [IDXW-1:0]       rank_next [ENTRIES];
    logic [CNTW-1:0]       vcnt_reg, vcnt_next;
    logic [31:0]           hits_reg, hits_next;
    logic [31:0]           misses_reg, misses_next;
    logic                  invf_reg, invf_next;
    logic [IDXW-1:0]       invi_reg, invi_next;
    logic [IDXW-1:0]       maxi_reg, maxi_next;
    logic [IDXW-1:0]       maxr_reg, maxr_next;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_data_reg;

    logic                  out_free;
    logic                  emit;
    rsp_t                  e;
    logic                  ram_we, ram_re;
    logic [IDXW-1:0]       ram_waddr, ram_raddr;
    logic [MAXSEC_W+31:0]  ram_wdata, ram_rdata;
    logic [31:0]           es, ee, rend, elen;
    logic                  touch_en, drop_en;
    logic [IDXW-1:0]       tgt;
    logic [CNTW-1:0]       old_rank;
    logic                  cur_v;
    logic [IDXW-1:0]       cur_r;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {{(32-MAXSEC_W){1'b0}}, maxsec_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxsec_reg <= MAXSEC_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == 3'd0)
        begin
            maxsec_reg <= pwdata[MAXSEC_W-1:0];
        end
    end

    // entry range store: {first_sector, length}
    srlc_ram #(.WIDTH(MAXSEC_W + 32), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // fields of the entry under test
    assign es    = ram_rdata[MAXSEC_W+31:MAXSEC_W];
    assign elen  = {{(32-MAXSEC_W){1'b0}}, ram_rdata[MAXSEC_W-1:0]};
    assign ee    = es + elen;
    assign rend  = start_reg + count_reg;
    assign cur_v = valid_reg[idx_reg];
    assign cur_r = rank_reg[idx_reg];

    // request sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        vcnt_next   = vcnt_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        invf_next   = invf_reg;
        invi_next   = invi_reg;
        maxi_next   = maxi_reg;
        maxr_next   = maxr_reg;
        ram_re      = 1'b0;
        ram_raddr   = idx_reg + 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = {start_reg, count_reg[MAXSEC_W-1:0]};
        touch_en    = 1'b0;
        drop_en     = 1'b0;
        tgt         = idx_reg;
        emit        = 1'b0;
        e           = '0;
        e.kind      = K_BYPASS;
        e.last      = 1'b1;
        for (int j = 0; j < ENTRIES; j++)
        begin
            valid_next[j] = valid_reg[j];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    op_next    = req.data.op;
                    start_next = req.data.first_sector;
                    count_next = req.data.sector_total;
                    idx_next   = '0;
                    invf_next  = 1'b0;
                    ram_raddr  = '0;
                    if (req.data.op == OP_READ
                        && req.data.sector_total > {21'd0, maxsec_reg})
                    begin
                        emit = 1'b1;
                    end
                    else if (req.data.op == OP_WRITE && !req.data.disk_ok)
                    begin
                        emit   = 1'b1;
                        e.kind = K_WERR;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    e.entry_index = 6'(idx_reg);
                    if (op_reg == OP_READ)
                    begin
                        if (cur_v && start_reg >= es && rend <= ee)
                        begin
                            emit            = 1'b1;
                            e.kind          = K_HIT;
                            e.sector_offset = start_reg - es;
                            e.sector_len    = count_reg;
                            touch_en        = 1'b1;
                            hits_next       = hits_reg + 32'd1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            // victim tracking across the scan
                            if (!invf_reg && !cur_v)
                            begin
                                invf_next = 1'b1;
                                invi_next = idx_reg;
                            end
                            if (idx_reg == '0 || cur_r > maxr_reg)
                            begin
                                maxi_next = idx_reg;
                                maxr_next = cur_r;
                            end
                            if (idx_reg == LAST_IDX)
                            begin
                                tgt             = invf_next ? invi_next : maxi_next;
                                touch_en        = 1'b1;
                                ram_we          = 1'b1;
                                ram_waddr       = tgt;
                                valid_next[tgt] = 1'b1;
                                if (!valid_reg[tgt])
                                begin
                                    vcnt_next = vcnt_reg + 1'b1;
                                end
                                misses_next     = misses_reg + 32'd1;
                                emit            = 1'b1;
                                e.kind          = K_FILL;
                                e.entry_index   = 6'(tgt);
                                e.fill_sector   = start_reg;
                                e.sector_len    = count_reg;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                                ram_re   = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (cur_v && start_reg < ee && rend > es)
                        begin
                            emit   = 1'b1;
                            e.last = 1'b0;
                            if (start_reg <= es && rend >= ee)
                            begin
                                e.kind          = K_WHOLE;
                                e.sector_offset = es - start_reg;
                                e.sector_len    = elen;
                                touch_en        = 1'b1;
                            end
                            else if (start_reg >= es && rend <= ee)
                            begin
                                e.kind          = K_PART;
                                e.sector_offset = start_reg - es;
                                e.sector_len    = count_reg;
                                touch_en        = 1'b1;
                            end
                            else
                            begin
                                e.kind              = K_INVAL;
                                drop_en             = 1'b1;
                                valid_next[idx_reg] = 1'b0;
                                vcnt_next           = vcnt_reg - 1'b1;
                            end
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            ram_re   = 1'b1;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e.kind     = K_WDONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        e.hits   = hits_next;
        e.misses = misses_next;
    end

    // recency rank update for touch and drop
    always_comb
    begin
        old_rank = valid_reg[tgt] ? CNTW'(rank_reg[tgt]) : vcnt_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
            if (IDXW'(j) == tgt)
            begin
                if (touch_en || drop_en)
                begin
                    rank_next[j] = '0;
                end
            end
            else if (valid_reg[j])
            begin
                if (touch_en && CNTW'(rank_reg[j]) < old_rank)
                begin
                    rank_next[j] = rank_reg[j] + 1'b1;
                end
                else if (drop_en && rank_reg[j] > rank_reg[tgt])
                begin
                    rank_next[j] = rank_reg[j] - 1'b1;
                end
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            vcnt_reg      <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            invf_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                valid_reg[j] <= 1'b0;
                rank_reg[j]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            vcnt_reg   <= vcnt_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            invf_reg   <= invf_next;
            for (int j = 0; j < ENTRIES; j++)
            begin
                valid_reg[j] <= valid_next[j];
                rank_reg[j]  <= rank_next[j];
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request payload, tracker and result payload
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        start_reg <= start_next;
        count_reg <= count_next;
        invi_reg  <= invi_next;
        maxi_reg  <= maxi_next;
        maxr_reg  <= maxr_next;
        if (emit)
        begin
            rsp_data_reg <= e;
        end
    end

    logic [ENTRIES-1:0] valid_vec;
    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            valid_vec[j] = valid_reg[j];
        end
    end

    // valid count tracks the valid bits
    a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
        CNTW'($countones(valid_vec)) == vcnt_reg)
        else $error("valid count mismatch");

    // hit counter advances by at most one per cycle
    a_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (hits_reg == $past(hits_reg)) || (hits_reg == $past(hits_reg) + 32'd1))
        else $error("hit counter jump");

    // a taken request starts a scan or leaves a result in the output register
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE) || rsp_valid_reg)
        else $error("request produced nothing");

    // write done follows the scan of a write
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (op_reg == OP_WRITE))
        else $error("done state on a read");

endmodule
